### rtl/at_response_terminator_detector_assert.svh
// Assertion macros for the AT reply collector.
// Used by at_response_terminator_detector; expects i_clk and i_rst_n in scope.
`ifndef AT_RESPONSE_TERMINATOR_DETECTOR_ASSERT_SVH
`define AT_RESPONSE_TERMINATOR_DETECTOR_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define ATRTD_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("atrtd: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define ATRTD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("atrtd: next-cycle check failed");

`endif

### rtl/atrtd_pkg.sv
// Shared types and constants for the AT reply collector.
// No dependencies; imported by every module of the block.
package atrtd_pkg;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_BYTE  = 2'd1,
        OP_TICK  = 2'd2,
        OP_UART  = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_BYTE = 2'd1,
        ST_FULL    = 2'd2,
        ST_UART    = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        EXIT_NONE    = 3'd0,
        EXIT_OK      = 3'd1,
        EXIT_ERROR   = 3'd2,
        EXIT_INTER   = 3'd3,
        EXIT_OVERALL = 3'd4,
        EXIT_FULL    = 3'd5,
        EXIT_UART    = 3'd6
    } t_exit;

    typedef enum logic [1:0] {
        CFG_CAPACITY = 2'd0,
        CFG_OVERALL  = 2'd1,
        CFG_INTER    = 2'd2
    } t_cfg_idx;

    localparam logic [12:0] CAPACITY_RST = 13'd256;
    localparam logic [15:0] OVERALL_RST  = 16'd5000;
    localparam logic [15:0] INTER_RST    = 16'd1000;
    localparam logic [15:0] MS_MAX       = 16'hFFFF;

    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_SP = 8'h20;
    localparam logic [7:0] CH_O  = 8'h4F;
    localparam logic [7:0] CH_K  = 8'h4B;
    localparam logic [7:0] CH_E  = 8'h45;
    localparam logic [7:0] CH_R  = 8'h52;

    localparam logic [2:0] OK_LEN  = 3'd4;
    localparam logic [2:0] ERR_LEN = 3'd7;

    typedef struct packed {
        logic [12:0] capacity;
        logic [15:0] overall_ms;
        logic [15:0] inter_ms;
    } t_cfg;

    typedef struct packed {
        logic [2:0] ok_next;
        logic [2:0] err_next;
        logic       ok_hit;
        logic       err_hit;
    } t_match;

    // Packed from the top down so byte_kept lands in bit 0.
    typedef struct packed {
        logic        saw_any_byte;
        logic [11:0] bytes_received;
        t_exit       exit_reason;
        t_status     status;
        logic        done_res;
        logic [7:0]  kept_byte;
        logic        byte_kept;
    } t_result;

    typedef struct packed {
        logic active;
        logic stored_nz;
    } t_sess_mon;

endpackage

### rtl/atrtd_match.sv
// Streaming matchers for the "\nOK\n" and "\nERROR\n" reply terminators.
// Depends on atrtd_pkg.
module atrtd_match (
    input  logic [2:0]       i_ok_prog,
    input  logic [2:0]       i_err_prog,
    input  logic [7:0]       i_byte,
    output atrtd_pkg::t_match o_match
);
    import atrtd_pkg::*;

    logic [2:0] w_ok;
    logic [2:0] w_err;

    // Neither pattern has an inner LF, so any LF that does not complete a pattern falls back to progress 1.
    always_comb begin
        w_ok = (i_byte == CH_LF) ? 3'd1 : 3'd0;
        case (i_ok_prog)
            3'd1: if (i_byte == CH_O) w_ok = 3'd2;
            3'd2: if (i_byte == CH_K) w_ok = 3'd3;
            3'd3: if (i_byte == CH_LF) w_ok = OK_LEN;
            default: ;
        endcase
    end

    always_comb begin
        w_err = (i_byte == CH_LF) ? 3'd1 : 3'd0;
        case (i_err_prog)
            3'd1: if (i_byte == CH_E) w_err = 3'd2;
            3'd2: if (i_byte == CH_R) w_err = 3'd3;
            3'd3: if (i_byte == CH_R) w_err = 3'd4;
            3'd4: if (i_byte == CH_O) w_err = 3'd5;
            3'd5: if (i_byte == CH_R) w_err = 3'd6;
            3'd6: if (i_byte == CH_LF) w_err = ERR_LEN;
            default: ;
        endcase
    end

    assign o_match.ok_next  = w_ok;
    assign o_match.err_next = w_err;
    assign o_match.ok_hit   = (w_ok == OK_LEN);
    assign o_match.err_hit  = (w_err == ERR_LEN);

endmodule

### rtl/atrtd_session.sv
// Session state and per-item result logic of the AT reply collector.
// Depends on atrtd_pkg and atrtd_match.
module atrtd_session #(
    parameter int MAX_CAPACITY = 4096
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  atrtd_pkg::t_opcode   i_opcode,
    input  logic [7:0]           i_rx_byte,
    input  atrtd_pkg::t_cfg      i_cfg,
    output atrtd_pkg::t_result   o_result,
    output atrtd_pkg::t_sess_mon o_mon
);
    import atrtd_pkg::*;

    localparam int CAP_LIM = (MAX_CAPACITY < 8191) ? MAX_CAPACITY : 8191;
    localparam int LEN_W   = $clog2(CAP_LIM);
    localparam int CMP_W   = 17;
    localparam logic [CMP_W-1:0] MAX_CAP = CMP_W'(MAX_CAPACITY);

    logic             r_active,    n_active;
    logic [15:0]      r_elapsed,   n_elapsed;
    logic [15:0]      r_idle,      n_idle;
    logic [LEN_W-1:0] r_stored,    n_stored;
    logic [2:0]       r_ok_prog,   n_ok_prog;
    logic [2:0]       r_err_prog,  n_err_prog;
    logic             r_any,       n_any;
    logic [LEN_W-1:0] r_lead,      n_lead;
    logic [LEN_W-1:0] r_trail,     n_trail;
    logic             r_nonblank,  n_nonblank;

    t_match           w_match;
    logic             w_full;
    logic             w_blank;
    logic [CMP_W-1:0] w_len_plus;
    logic [LEN_W-1:0] b_stored, b_lead, b_trail;
    logic             b_nonblank;
    logic             w_use_b;
    logic [LEN_W-1:0] t_stored, t_lead, t_trail;
    logic             t_nonblank;
    logic [LEN_W:0]   w_cut;
    logic [LEN_W-1:0] w_trimmed;
    logic [15:0]      w_elapsed_inc, w_idle_inc;
    logic [31:0]      w_cnt_ext;
    logic [LEN_W-1:0] w_cnt;

    atrtd_match u_match (
        .i_ok_prog  (r_ok_prog),
        .i_err_prog (r_err_prog),
        .i_byte     (i_rx_byte),
        .o_match    (w_match)
    );

    assign w_len_plus = CMP_W'(r_stored) + CMP_W'(1);
    assign w_full     = (w_len_plus >= CMP_W'(i_cfg.capacity)) || (w_len_plus >= MAX_CAP);
    assign w_blank    = (i_rx_byte == CH_LF) || (i_rx_byte == CH_SP);

    // Values after appending the byte.
    always_comb begin
        b_stored   = r_stored + LEN_W'(1);
        b_lead     = r_lead;
        b_trail    = r_trail;
        b_nonblank = r_nonblank;
        if (w_blank) begin
            if (r_nonblank) b_trail = r_trail + LEN_W'(1);
            else            b_lead  = r_lead + LEN_W'(1);
        end else begin
            b_nonblank = 1'b1;
            b_trail    = '0;
        end
    end

    assign w_use_b    = (i_opcode == OP_BYTE);
    assign t_stored   = w_use_b ? b_stored   : r_stored;
    assign t_lead     = w_use_b ? b_lead     : r_lead;
    assign t_trail    = w_use_b ? b_trail    : r_trail;
    assign t_nonblank = w_use_b ? b_nonblank : r_nonblank;
    assign w_cut      = (LEN_W+1)'(t_lead) + (LEN_W+1)'(t_trail);

    always_comb begin
        if (!t_nonblank || (w_cut >= {1'b0, t_stored})) w_trimmed = '0;
        else w_trimmed = t_stored - w_cut[LEN_W-1:0];
    end

    assign w_elapsed_inc = (r_elapsed == MS_MAX) ? r_elapsed : r_elapsed + 16'd1;
    assign w_idle_inc    = (r_idle == MS_MAX) ? r_idle : r_idle + 16'd1;

    always_comb begin
        n_active   = r_active;
        n_elapsed  = r_elapsed;
        n_idle     = r_idle;
        n_stored   = r_stored;
        n_ok_prog  = r_ok_prog;
        n_err_prog = r_err_prog;
        n_any      = r_any;
        n_lead     = r_lead;
        n_trail    = r_trail;
        n_nonblank = r_nonblank;
        o_result   = '0;
        w_cnt      = '0;
        if (i_opcode == OP_START) begin
            n_active   = 1'b1;
            n_elapsed  = '0;
            n_idle     = '0;
            n_stored   = '0;
            n_ok_prog  = '0;
            n_err_prog = '0;
            n_any      = 1'b0;
            n_lead     = '0;
            n_trail    = '0;
            n_nonblank = 1'b0;
        end else if (r_active) begin
            case (i_opcode)
                OP_BYTE: begin
                    n_any  = 1'b1;
                    n_idle = '0;
                    if (i_rx_byte != CH_CR) begin
                        if (w_full) begin
                            n_active           = 1'b0;
                            o_result.done_res  = 1'b1;
                            o_result.status    = ST_FULL;
                            o_result.exit_reason = EXIT_FULL;
                            w_cnt              = r_stored;
                        end else begin
                            n_stored           = b_stored;
                            n_lead             = b_lead;
                            n_trail            = b_trail;
                            n_nonblank         = b_nonblank;
                            n_ok_prog          = w_match.ok_next;
                            n_err_prog         = w_match.err_next;
                            o_result.byte_kept = 1'b1;
                            o_result.kept_byte = i_rx_byte;
                            if (w_match.ok_hit) begin
                                n_ok_prog            = '0;
                                n_active             = 1'b0;
                                o_result.done_res    = 1'b1;
                                o_result.exit_reason = EXIT_OK;
                                w_cnt                = w_trimmed;
                            end else if (w_match.err_hit) begin
                                n_err_prog           = '0;
                                n_active             = 1'b0;
                                o_result.done_res    = 1'b1;
                                o_result.exit_reason = EXIT_ERROR;
                                w_cnt                = w_trimmed;
                            end
                        end
                    end
                end
                OP_TICK: begin
                    n_elapsed = w_elapsed_inc;
                    n_idle    = w_idle_inc;
                    if (w_elapsed_inc >= i_cfg.overall_ms) begin
                        n_active             = 1'b0;
                        o_result.done_res    = 1'b1;
                        o_result.exit_reason = EXIT_OVERALL;
                        if (r_any) begin
                            w_cnt = w_trimmed;
                        end else begin
                            o_result.status = ST_NO_BYTE;
                        end
                    end else if (r_any && (w_idle_inc >= i_cfg.inter_ms)) begin
                        n_active             = 1'b0;
                        o_result.done_res    = 1'b1;
                        o_result.exit_reason = EXIT_INTER;
                        w_cnt                = w_trimmed;
                    end
                end
                default: begin
                    n_active             = 1'b0;
                    o_result.done_res    = 1'b1;
                    o_result.status      = ST_UART;
                    o_result.exit_reason = EXIT_UART;
                    w_cnt                = r_stored;
                end
            endcase
            if (!o_result.done_res) w_cnt = n_stored;
            o_result.saw_any_byte = n_any;
        end
        w_cnt_ext               = {{(32-LEN_W){1'b0}}, w_cnt};
        o_result.bytes_received = w_cnt_ext[11:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 1'b0;
            r_elapsed  <= '0;
            r_idle     <= '0;
            r_stored   <= '0;
            r_ok_prog  <= '0;
            r_err_prog <= '0;
            r_any      <= 1'b0;
            r_lead     <= '0;
            r_trail    <= '0;
            r_nonblank <= 1'b0;
        end else if (i_step) begin
            r_active   <= n_active;
            r_elapsed  <= n_elapsed;
            r_idle     <= n_idle;
            r_stored   <= n_stored;
            r_ok_prog  <= n_ok_prog;
            r_err_prog <= n_err_prog;
            r_any      <= n_any;
            r_lead     <= n_lead;
            r_trail    <= n_trail;
            r_nonblank <= n_nonblank;
        end
    end

    assign o_mon.active    = r_active;
    assign o_mon.stored_nz = (r_stored != '0);

endmodule

### rtl/at_response_terminator_detector.sv
// AT reply collector top level: input register, session logic, result register.
// Depends on atrtd_pkg, atrtd_session and at_response_terminator_detector_assert.svh.
//
//  channel  | direction | payload
//  ---------+-----------+------------------------------------------------------
//  s_axis   | in        | tdata: rx_byte; tuser: opcode
//  m_axis   | out       | tdata: byte_kept .. saw_any_byte (one result per item)
//  cfg      | in        | i_cfg_index selects register, i_cfg_data holds value
//
// One item per cycle sustained while m_axis accepts; each item is held in the input
// register until the result register is free and is then evaluated into it.
// Synchronous active-low reset clears the session and loads register defaults.
// A stalled m_axis holds the result and, once the input register is full,
// drops s_axis_tready; the config channel is always ready.
module at_response_terminator_detector #(
    parameter int MAX_CAPACITY = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] byte_kept, [8:1] kept_byte, [9] done_res, [11:10] status,
    // [14:12] exit_reason, [26:15] bytes_received, [27] saw_any_byte
    output logic [31:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import atrtd_pkg::*;

    `include "at_response_terminator_detector_assert.svh"

    logic      r_in_valid, n_in_valid;
    t_opcode   r_in_op;
    logic [7:0] r_in_byte;
    logic      r_out_valid, n_out_valid;
    t_result   r_out;
    t_cfg      r_cfg, n_cfg;

    logic      w_in_acc;
    logic      w_out_free;
    logic      w_step;
    t_result   w_result;
    t_sess_mon w_mon;
    logic      w_kept_done;
    logic      w_match_exit;

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_step        = r_in_valid && w_out_free;
    assign s_axis_tready = !r_in_valid || w_out_free;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign n_in_valid    = w_in_acc || (r_in_valid && !w_step);
    assign n_out_valid   = w_step || (r_out_valid && !m_axis_tready);

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CAPACITY: n_cfg.capacity   = i_cfg_data[12:0];
                CFG_OVERALL:  n_cfg.overall_ms = i_cfg_data;
                CFG_INTER:    n_cfg.inter_ms   = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_cfg.capacity   <= CAPACITY_RST;
            r_cfg.overall_ms <= OVERALL_RST;
            r_cfg.inter_ms   <= INTER_RST;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            r_cfg       <= n_cfg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_op   <= t_opcode'(s_axis_tuser);
            r_in_byte <= s_axis_tdata;
        end
        if (w_step) begin
            r_out <= w_result;
        end
    end

    atrtd_session #(
        .MAX_CAPACITY (MAX_CAPACITY)
    ) u_session (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_step),
        .i_opcode  (r_in_op),
        .i_rx_byte (r_in_byte),
        .i_cfg     (r_cfg),
        .o_result  (w_result),
        .o_mon     (w_mon)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out};

    assign w_kept_done  = r_out_valid && r_out.byte_kept && r_out.done_res;
    assign w_match_exit = (r_out.exit_reason == EXIT_OK) || (r_out.exit_reason == EXIT_ERROR);

    `ATRTD_ASSERT_SAME(a_done_closes_session, r_out_valid && r_out.done_res, !w_mon.active)
    `ATRTD_ASSERT_SAME(a_kept_done_is_match, w_kept_done, w_match_exit)
    `ATRTD_ASSERT_SAME(a_kept_has_length, r_out_valid && r_out.byte_kept, w_mon.stored_nz)
    `ATRTD_ASSERT_NEXT(a_stalled_item_held, r_in_valid && !w_step, r_in_valid)

endmodule
